// ===== design/assert_macros.svh =====
// shared assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked property, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked property that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== design/nlp_pkg.sv =====
package nlp_pkg;

	localparam int VALUE_WIDTH_DEF = 64;
	localparam int CHAR_W          = 8;
	localparam int BITS_W          = 8;
	localparam int IN_TDATA_W      = 16;

	localparam logic [BITS_W-1:0] BITS_MAX = '1;

	// one input character as held in the input stage
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              start_req;
		logic [BITS_W-1:0] dflt_bits;
	} in_item_t;

endpackage

// ===== design/nlp_in_stage.sv =====
module nlp_in_stage
	import nlp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // ch, dflt_bits
	input  logic                  s_axis_tuser,  // start_req
	input  logic                  adv,
	output logic                  fire,
	output in_item_t              item_s1
);

	logic valid_s1;

	assign s_axis_tready = !valid_s1 || adv;
	assign fire          = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.ch        <= s_axis_tdata[CHAR_W-1:0];
			item_s1.dflt_bits <= s_axis_tdata[CHAR_W +: BITS_W];
			item_s1.start_req <= s_axis_tuser;
		end
	end

endmodule

// ===== design/nlp_parse.sv =====
`include "assert_macros.svh"

module nlp_parse
	import nlp_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  in_item_t               item_s1,
	output logic                   emit,
	output logic [VALUE_WIDTH-1:0] res_value,
	output logic [BITS_W-1:0]      res_bits
);

	typedef enum logic [5:0] {
		MODE_DONE = 6'b000001,
		MODE_BIN  = 6'b000010,
		MODE_ZERO = 6'b000100,
		MODE_HEX  = 6'b001000,
		MODE_OCT  = 6'b010000,
		MODE_DEC  = 6'b100000
	} mode_t;

	localparam logic [CHAR_W-1:0] CH_HASH = 8'h23;
	localparam logic [CHAR_W-1:0] CH_0    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_1    = 8'h31;
	localparam logic [CHAR_W-1:0] CH_7    = 8'h37;
	localparam logic [CHAR_W-1:0] CH_9    = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA   = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UF   = 8'h46;
	localparam logic [CHAR_W-1:0] CH_LA   = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LF   = 8'h66;
	localparam logic [CHAR_W-1:0] CH_X    = 8'h78;
	localparam logic [CHAR_W-1:0] HEX_UOFS = CH_UA - 8'd10;
	localparam logic [CHAR_W-1:0] HEX_LOFS = CH_LA - 8'd10;

	mode_t                  mode_q, mode_d;
	logic [VALUE_WIDTH-1:0] accum_q, accum_d;
	logic [BITS_W-1:0]      bitcnt_q, bitcnt_d;

	logic [CHAR_W-1:0]      ch;
	logic [CHAR_W-1:0]      dec_sub;
	logic [CHAR_W-1:0]      hex_sub;
	logic [3:0]             digit;
	logic [3:0]             hex_digit;
	logic                   is_bin, is_oct, is_dec, is_hex;
	logic [VALUE_WIDTH-1:0] dec_next;
	logic [VALUE_WIDTH-1:0] bin_next, oct_next, hex_next;
	logic [BITS_W:0]        sum1, sum3, sum4;
	logic [BITS_W-1:0]      sat1, sat3, sat4;

	assign ch      = item_s1.ch;
	assign dec_sub = ch - CH_0;
	assign digit   = dec_sub[3:0];
	assign is_bin  = (ch == CH_0) || (ch == CH_1);
	assign is_oct  = ch inside {[CH_0:CH_7]};
	assign is_dec  = ch inside {[CH_0:CH_9]};

	always_comb begin
		is_hex  = 1'b1;
		hex_sub = dec_sub;
		if (ch inside {[CH_LA:CH_LF]}) begin
			hex_sub = ch - HEX_LOFS;
		end else if (ch inside {[CH_UA:CH_UF]}) begin
			hex_sub = ch - HEX_UOFS;
		end else if (!is_dec) begin
			is_hex = 1'b0;
		end
	end
	assign hex_digit = hex_sub[3:0];

	// x*10 as (x<<3)+(x<<1), wrapped to the value width
	assign dec_next = (accum_q << 3) + (accum_q << 1) + VALUE_WIDTH'(digit);
	assign bin_next = (accum_q << 1) | VALUE_WIDTH'(digit);
	assign oct_next = (accum_q << 3) | VALUE_WIDTH'(digit);
	assign hex_next = (accum_q << 4) | VALUE_WIDTH'(hex_digit);

	assign sum1 = {1'b0, bitcnt_q} + (BITS_W+1)'(1);
	assign sum3 = {1'b0, bitcnt_q} + (BITS_W+1)'(3);
	assign sum4 = {1'b0, bitcnt_q} + (BITS_W+1)'(4);
	assign sat1 = sum1[BITS_W] ? BITS_MAX : sum1[BITS_W-1:0];
	assign sat3 = sum3[BITS_W] ? BITS_MAX : sum3[BITS_W-1:0];
	assign sat4 = sum4[BITS_W] ? BITS_MAX : sum4[BITS_W-1:0];

	always_comb begin
		mode_d    = mode_q;
		accum_d   = accum_q;
		bitcnt_d  = bitcnt_q;
		emit      = 1'b0;
		res_value = accum_q;
		res_bits  = bitcnt_q;
		if (item_s1.start_req) begin
			accum_d  = '0;
			bitcnt_d = '0;
			if (ch == CH_HASH) begin
				mode_d = MODE_BIN;
			end else if (ch == CH_0) begin
				mode_d = MODE_ZERO;
			end else if (is_dec) begin
				accum_d = VALUE_WIDTH'(digit);
				mode_d  = MODE_DEC;
			end else begin
				// bad first character
				emit      = 1'b1;
				res_value = '0;
				res_bits  = '0;
				mode_d    = MODE_DONE;
			end
		end else begin
			case (mode_q)
				MODE_BIN: begin
					if (is_bin) begin
						accum_d  = bin_next;
						bitcnt_d = sat1;
					end else begin
						emit   = 1'b1;
						mode_d = MODE_DONE;
					end
				end
				MODE_ZERO: begin
					if (ch == CH_X) begin
						mode_d = MODE_HEX;
					end else if (is_oct) begin
						accum_d  = VALUE_WIDTH'(digit);
						bitcnt_d = BITS_W'(3);
						mode_d   = MODE_OCT;
					end else begin
						// plain zero
						emit      = 1'b1;
						res_value = '0;
						res_bits  = item_s1.dflt_bits;
						mode_d    = MODE_DONE;
					end
				end
				MODE_HEX: begin
					if (is_hex) begin
						accum_d  = hex_next;
						bitcnt_d = sat4;
					end else begin
						emit   = 1'b1;
						mode_d = MODE_DONE;
					end
				end
				MODE_OCT: begin
					if (is_oct) begin
						accum_d  = oct_next;
						bitcnt_d = sat3;
					end else begin
						emit   = 1'b1;
						mode_d = MODE_DONE;
					end
				end
				MODE_DEC: begin
					if (is_dec) begin
						accum_d = dec_next;
					end else begin
						emit     = 1'b1;
						res_bits = item_s1.dflt_bits;
						mode_d   = MODE_DONE;
					end
				end
				default: begin
					mode_d = MODE_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_DONE;
			accum_q  <= '0;
			bitcnt_q <= '0;
		end else if (fire) begin
			mode_q   <= mode_d;
			accum_q  <= accum_d;
			bitcnt_q <= bitcnt_d;
		end
	end

	`ASSERT_CLK(a_emit_ends, clk, arst_n, (fire && emit) |=> (mode_q == MODE_DONE), "parser not done after result")
	`ASSERT_CLK(a_hold_state, clk, arst_n, !fire |=> ($stable(mode_q) && $stable(accum_q) && $stable(bitcnt_q)), "parser state moved without an item")
	`ASSERT_CLK(a_oct_bits, clk, arst_n, (mode_q == MODE_OCT) |-> (bitcnt_q >= BITS_W'(3)), "octal bit count below one digit")
	`ASSERT_CLK(a_dec_bits, clk, arst_n, (mode_q == MODE_DEC) |-> (bitcnt_q == '0), "decimal bit count not cleared")

endmodule

// ===== design/number_literal_parser.sv =====
// Numeric literal parser: one character per item on the input stream; an item with
// tuser set starts a new literal. Accepted forms are '#' + binary digits, "0x" + hex
// digits, '0' + octal digits and plain decimal; the first character that does not fit
// ends the literal and one result item (value, bit count) is sent, and characters after
// that are dropped until the next start. Decimal and lone zero take their bit count from
// dflt_bits of the terminating item. Throughput is one character per clock while no
// result waits on m_axis_tready: the step is a single shift-add (decimal uses
// x*8+x*2+digit) between the input register and the parser state, and the result is
// registered in the output register once the terminating item leaves the input register.
// A waiting result stalls the parser; only an empty input register takes a character.
`include "assert_macros.svh"

module number_literal_parser
	import nlp_pkg::*;
#(
	parameter  int VALUE_WIDTH = VALUE_WIDTH_DEF,
	localparam int OUT_TDATA_W = ((VALUE_WIDTH + BITS_W + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // ch, dflt_bits
	input  logic                   s_axis_tuser,  // start_req
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // value, bits, zero pad
);

	logic                   adv;
	logic                   fire;
	in_item_t               item_s1;
	logic                   emit;
	logic [VALUE_WIDTH-1:0] res_value;
	logic [BITS_W-1:0]      res_bits;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic [BITS_W-1:0]      out_bits_q;

	assign adv = !out_valid_q || m_axis_tready;

	nlp_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.adv           (adv),
		.fire          (fire),
		.item_s1       (item_s1)
	);

	nlp_parse #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item_s1   (item_s1),
		.emit      (emit),
		.res_value (res_value),
		.res_bits  (res_bits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_value_q <= res_value;
			out_bits_q  <= res_bits;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'({out_bits_q, out_value_q});

	`ASSERT_CLK(a_no_overwrite, clk, arst_n, (out_valid_q && !m_axis_tready) |-> !fire, "item taken while result stalled")
	`ASSERT_CLK(a_result_src, clk, arst_n, $rose(out_valid_q) |-> $past(fire && emit), "result without a terminating item")
	`ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !m_axis_tvalid, "result valid in reset")

endmodule

// ===== bench/tb.sv =====
module tb;
	import nlp_pkg::*;

	localparam int VW          = VALUE_WIDTH_DEF;
	localparam int OUT_W       = ((VW + BITS_W + 7) / 8) * 8;
	localparam int ITEM_COUNT  = 500;
	localparam int TAIL_CYCLES = 16;
	localparam int CYCLE_LIMIT = 500000;

	localparam logic [63:0] VMASK = {64{1'b1}} >> (64 - VW);

	localparam logic [7:0] CH_HASH  = "#";
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_ONE   = "1";
	localparam logic [7:0] CH_SEVEN = "7";
	localparam logic [7:0] CH_NINE  = "9";
	localparam logic [7:0] CH_X     = "x";
	localparam logic [7:0] CH_LA    = "a";
	localparam logic [7:0] CH_LF    = "f";
	localparam logic [7:0] CH_UA    = "A";
	localparam logic [7:0] CH_UF    = "F";

	typedef enum logic [2:0] {
		FORM_DONE,
		FORM_BIN,
		FORM_ZERO,
		FORM_HEX,
		FORM_OCT,
		FORM_DEC
	} form_t;

	typedef struct packed {
		logic [63:0]       value;
		logic [BITS_W-1:0] bits;
	} literal_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;   // ch, dflt_bits
	logic                  s_axis_tuser;   // start_req
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_W-1:0]      m_axis_tdata;   // value, bits, zero pad

	number_literal_parser u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// parser state as the predictor sees it
	form_t             pm_form  = FORM_DONE;
	logic [63:0]       pm_accum = '0;
	logic [BITS_W-1:0] pm_bits  = '0;

	literal_t literal_q[$];
	int       errors      = 0;
	int       chars_sent  = 0;
	int       cycles      = 0;
	int       stall_left  = 0;
	bit       tx_steady   = 0;
	bit       rx_steady   = 0;

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit in_rng(input logic [7:0] c, input logic [7:0] lo,
			input logic [7:0] hi);
		return c >= lo && c <= hi;
	endfunction

	// 16 when c is no hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		if (in_rng(c, CH_ZERO, CH_NINE))
			return 5'(c - CH_ZERO);
		if (in_rng(c, CH_LA, CH_LF))
			return 5'(c - CH_LA + 10);
		if (in_rng(c, CH_UA, CH_UF))
			return 5'(c - CH_UA + 10);
		return 5'd16;
	endfunction

	function automatic logic [BITS_W-1:0] sat_add(input logic [BITS_W-1:0] a, input int n);
		int s;
		s = a + n;
		return (s > BITS_MAX) ? BITS_MAX : s[BITS_W-1:0];
	endfunction

	function automatic bit char_fits(input form_t form, input logic [7:0] c);
		case (form)
			FORM_BIN:  return in_rng(c, CH_ZERO, CH_ONE);
			FORM_HEX:  return hex_digit(c) < 16;
			FORM_OCT:  return in_rng(c, CH_ZERO, CH_SEVEN);
			FORM_DEC:  return in_rng(c, CH_ZERO, CH_NINE);
			FORM_ZERO: return c == CH_X || in_rng(c, CH_ZERO, CH_SEVEN);
			default:   return 1'b0;
		endcase
	endfunction

	// advances the predicted parser by one character; 1 when a literal ends
	function automatic bit parse_char(input logic [7:0] c, input bit start,
			input logic [7:0] dflt, output literal_t lit);
		lit = '0;
		if (start) begin
			pm_accum = '0;
			pm_bits  = '0;
			if (c == CH_HASH) begin
				pm_form = FORM_BIN;
				return 1'b0;
			end
			if (c == CH_ZERO) begin
				pm_form = FORM_ZERO;
				return 1'b0;
			end
			if (in_rng(c, CH_ONE, CH_NINE)) begin
				pm_accum = 64'(c - CH_ZERO) & VMASK;
				pm_form  = FORM_DEC;
				return 1'b0;
			end
			pm_form = FORM_DONE;
			return 1'b1;
		end
		case (pm_form)
			FORM_BIN: begin
				if (in_rng(c, CH_ZERO, CH_ONE)) begin
					pm_accum = ((pm_accum << 1) + 64'(c - CH_ZERO)) & VMASK;
					pm_bits  = sat_add(pm_bits, 1);
					return 1'b0;
				end
				lit = '{value: pm_accum, bits: pm_bits};
			end
			FORM_ZERO: begin
				if (c == CH_X) begin
					pm_form = FORM_HEX;
					return 1'b0;
				end
				if (in_rng(c, CH_ZERO, CH_SEVEN)) begin
					pm_accum = 64'(c - CH_ZERO) & VMASK;
					pm_bits  = 8'd3;
					pm_form  = FORM_OCT;
					return 1'b0;
				end
				lit = '{value: '0, bits: dflt};
			end
			FORM_HEX: begin
				if (hex_digit(c) < 16) begin
					pm_accum = ((pm_accum << 4) + 64'(hex_digit(c))) & VMASK;
					pm_bits  = sat_add(pm_bits, 4);
					return 1'b0;
				end
				lit = '{value: pm_accum, bits: pm_bits};
			end
			FORM_OCT: begin
				if (in_rng(c, CH_ZERO, CH_SEVEN)) begin
					pm_accum = ((pm_accum << 3) + 64'(c - CH_ZERO)) & VMASK;
					pm_bits  = sat_add(pm_bits, 3);
					return 1'b0;
				end
				lit = '{value: pm_accum, bits: pm_bits};
			end
			FORM_DEC: begin
				if (in_rng(c, CH_ZERO, CH_NINE)) begin
					pm_accum = (pm_accum * 64'd10 + 64'(c - CH_ZERO)) & VMASK;
					return 1'b0;
				end
				lit = '{value: pm_accum, bits: dflt};
			end
			default: begin
				pm_form = FORM_DONE;
				return 1'b0;
			end
		endcase
		pm_form = FORM_DONE;
		return 1'b1;
	endfunction

	// mostly no gap, sometimes a short one, rarely a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 25);
	endfunction

	function automatic logic [7:0] rand_digit(input form_t form);
		case (form)
			FORM_BIN: return CH_ZERO + 8'($urandom_range(0, 1));
			FORM_OCT: return CH_ZERO + 8'($urandom_range(0, 7));
			FORM_DEC: return CH_ZERO + 8'($urandom_range(0, 9));
			default: begin
				case ($urandom_range(0, 2))
					0:       return CH_ZERO + 8'($urandom_range(0, 9));
					1:       return CH_LA + 8'($urandom_range(0, 5));
					default: return CH_UA + 8'($urandom_range(0, 5));
				endcase
			end
		endcase
	endfunction

	function automatic logic [7:0] rand_dflt();
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_char(input logic [7:0] c, input bit start, input logic [7:0] dflt);
		int       gap;
		literal_t lit;
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {dflt, c};
		s_axis_tuser  <= start;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		// characters dropped while idle do not count
		if (start || pm_form != FORM_DONE)
			chars_sent++;
		if (parse_char(c, start, dflt, lit))
			literal_q.push_back(lit);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (literal_q.size() != 0) @(posedge clk);
	endtask

	// result side: check each accepted item, then pick the next ready value
	always @(posedge clk) begin
		literal_t exp_lit;
		if (m_axis_tvalid && m_axis_tready) begin
			if (literal_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual value %h bits %0d",
					$time, m_axis_tdata[VW-1:0], m_axis_tdata[VW+BITS_W-1:VW]);
				errors++;
			end else begin
				exp_lit = literal_q.pop_front();
				if (m_axis_tdata[VW-1:0] !== exp_lit.value[VW-1:0]) begin
					$display("%0t: value mismatch, expected %h actual %h", $time,
						exp_lit.value[VW-1:0], m_axis_tdata[VW-1:0]);
					errors++;
				end
				if (m_axis_tdata[VW+BITS_W-1:VW] !== exp_lit.bits) begin
					$display("%0t: bits mismatch, expected %0d actual %0d", $time,
						exp_lit.bits, m_axis_tdata[VW+BITS_W-1:VW]);
					errors++;
				end
			end
		end
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
			if (!rx_steady)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, literal_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic test_each_form();
		// binary 101
		send_char(CH_HASH, 1, 8'h00);
		send_char(CH_ONE, 0, 8'h00);
		send_char(CH_ZERO, 0, 8'h00);
		send_char(CH_ONE, 0, 8'h00);
		send_char(" ", 0, 8'h00);
		// hex with both letter cases
		send_char(CH_ZERO, 1, 8'h11);
		send_char(CH_X, 0, 8'h11);
		send_char(CH_UF, 0, 8'h11);
		send_char(CH_LA, 0, 8'h11);
		send_char("g", 0, 8'h11);
		// octal ended by a decimal digit
		send_char(CH_ZERO, 1, 8'h22);
		send_char(CH_ONE, 0, 8'h22);
		send_char(CH_SEVEN, 0, 8'h22);
		send_char("8", 0, 8'h22);
		// decimal takes the bit count of the terminator
		send_char(CH_NINE, 1, 8'h00);
		send_char(CH_NINE, 0, 8'h00);
		send_char(CH_UF, 0, 8'hFF);
		// lone zero, uppercase x is not a hex prefix
		send_char(CH_ZERO, 1, 8'h00);
		send_char("X", 0, 8'hA5);
	endtask

	task automatic test_special_cases();
		// bad first character, then idle characters are dropped
		send_char(8'hFF, 1, 8'hFF);
		send_char(CH_ONE, 0, 8'h5A);
		send_char(8'h00, 0, 8'h00);
		// prefixes with no digits
		send_char(CH_HASH, 1, 8'h77);
		send_char("2", 0, 8'h77);
		send_char(CH_ZERO, 1, 8'h33);
		send_char(CH_X, 0, 8'h33);
		send_char(8'h80, 0, 8'h33);
		// restart in the middle of a literal drops the old one
		send_char(CH_HASH, 1, 8'h00);
		send_char(CH_ONE, 0, 8'h00);
		send_char("5", 1, 8'h00);
		send_char(8'h00, 0, 8'h00);
	endtask

	task automatic test_overflow();
		tx_steady = 1;
		rx_steady = 1;
		// 70 hex digits: value wraps and bit count saturates
		send_char(CH_ZERO, 1, rand_dflt());
		send_char(CH_X, 0, rand_dflt());
		repeat (70) send_char(rand_digit(FORM_HEX), 0, rand_dflt());
		send_char(" ", 0, rand_dflt());
		send_char(CH_NINE, 1, rand_dflt());
		repeat (24) send_char(rand_digit(FORM_DEC), 0, rand_dflt());
		send_char(".", 0, rand_dflt());
		send_char(CH_HASH, 1, rand_dflt());
		repeat (70) send_char(CH_ONE, 0, rand_dflt());
		send_char(8'hFF, 0, rand_dflt());
		send_char(CH_ZERO, 1, rand_dflt());
		repeat (25) send_char(CH_SEVEN, 0, rand_dflt());
		send_char(CH_NINE, 0, rand_dflt());
		tx_steady = 0;
		rx_steady = 0;
		drain_results();
	endtask

	task automatic send_random_literal();
		int          pick;
		int          ndig;
		form_t       form;
		form_t       term_form;
		logic [7:0]  c;
		if ($urandom_range(0, 19) == 0)
			tx_steady = !tx_steady;
		if ($urandom_range(0, 19) == 0)
			rx_steady = !rx_steady;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)), 0, rand_dflt());
			return;
		end
		if (pick < 15) begin
			do
				c = 8'($urandom_range(0, 255));
			while (c == CH_HASH || in_rng(c, CH_ZERO, CH_NINE));
			send_char(c, 1, rand_dflt());
			return;
		end
		ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
		if (pick < 33) begin
			form = FORM_BIN;
			send_char(CH_HASH, 1, rand_dflt());
		end else if (pick < 51) begin
			form = FORM_HEX;
			send_char(CH_ZERO, 1, rand_dflt());
			send_char(CH_X, 0, rand_dflt());
		end else if (pick < 67) begin
			form = FORM_OCT;
			send_char(CH_ZERO, 1, rand_dflt());
		end else if (pick < 87) begin
			form = FORM_DEC;
			send_char(CH_ONE + 8'($urandom_range(0, 8)), 1, rand_dflt());
		end else begin
			form = FORM_ZERO;
			ndig = 0;
			send_char(CH_ZERO, 1, rand_dflt());
		end
		repeat (ndig) send_char(rand_digit(form), 0, rand_dflt());
		// an octal start with no digits is still a lone zero
		term_form = (form == FORM_OCT && ndig == 0) ? FORM_ZERO : form;
		if ($urandom_range(0, 99) < 6)
			return;
		do
			c = 8'($urandom_range(0, $urandom_range(0, 1) ? 127 : 255));
		while (char_fits(term_form, c));
		send_char(c, 0, rand_dflt());
	endtask

	task automatic test_random();
		while (chars_sent < ITEM_COUNT) send_random_literal();
		tx_steady = 0;
		rx_steady = 0;
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		m_axis_tready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_each_form();
		test_special_cases();
		test_overflow();
		test_random();
		s_axis_tvalid <= 1'b0;
		while (literal_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
